// File: rtl/core/pls_pkg.sv
package pls_pkg;

  localparam int POS_W      = 5;
  localparam int ITEM_IN_W  = 32;
  localparam int ITEM_OUT_W = 32;
  localparam int CNT_OUT_W  = 5;

  localparam logic [1:0] ACT_INSERT   = 2'd0;
  localparam logic [1:0] ACT_REMOVE   = 2'd1;
  localparam logic [1:0] ACT_RETRIEVE = 2'd2;

  // Command broadcast to every cell of the chain for one request.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic             rd;
    logic [POS_W-1:0] idx;
  } pls_cmd_t;

endpackage

// File: rtl/core/pls_ctrl.sv
module pls_ctrl #(
  parameter int DEPTH = 16,
  parameter int CW    = 5
) (
  input  logic                        accept,
  input  logic [1:0]                  action,
  input  logic [pls_pkg::POS_W-1:0]   position,
  input  logic [CW-1:0]               count,
  output pls_pkg::pls_cmd_t           cmd,
  output logic                        ok,
  output logic [CW-1:0]               count_next
);
  import pls_pkg::*;

  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [CMPW-1:0] pos_e;
  logic [CMPW-1:0] cnt_e;
  logic [CMPW-1:0] depth_e;
  logic            pos_nz;

  assign pos_e   = CMPW'(position);
  assign cnt_e   = CMPW'(count);
  assign depth_e = CMPW'(DEPTH);
  assign pos_nz  = (position != '0);

  always_comb begin
    cmd        = '0;
    cmd.idx    = position - 1'b1;
    ok         = 1'b0;
    count_next = count;
    if (accept) begin
      unique case (action)
        ACT_INSERT: begin
          if (pos_nz && pos_e <= cnt_e + 1'b1 && cnt_e < depth_e) begin
            cmd.ins    = 1'b1;
            ok         = 1'b1;
            count_next = count + 1'b1;
          end
        end
        ACT_REMOVE: begin
          if (pos_nz && pos_e <= cnt_e) begin
            cmd.rem    = 1'b1;
            ok         = 1'b1;
            count_next = count - 1'b1;
          end
        end
        ACT_RETRIEVE: begin
          if (pos_nz && pos_e <= cnt_e) begin
            cmd.rd = 1'b1;
            ok     = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/pls_cell.sv
module pls_cell #(
  parameter int INDEX      = 0,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                    clk,
  input  pls_pkg::pls_cmd_t       cmd,
  input  logic [ITEM_WIDTH-1:0]   item,
  input  logic [ITEM_WIDTH-1:0]   left,
  input  logic [ITEM_WIDTH-1:0]   right,
  output logic [ITEM_WIDTH-1:0]   data,
  output logic [ITEM_WIDTH-1:0]   rd_data
);
  import pls_pkg::*;

  localparam logic [7:0] IDX = 8'(INDEX);

  logic [7:0]            sel;
  logic [ITEM_WIDTH-1:0] data_next;

  assign sel = 8'(cmd.idx);

  always_comb begin
    data_next = data;
    if (cmd.ins && IDX == sel) begin
      data_next = item;
    end else if (cmd.ins && IDX > sel) begin
      data_next = left;
    end else if (cmd.rem && IDX >= sel) begin
      data_next = right;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Only the addressed cell drives its value onto the read chain.
  assign rd_data = (cmd.rd && IDX == sel) ? data : '0;

endmodule

// File: rtl/core/positional_list_store.sv
// Result: a request accepted at a clock edge has its result on the outputs, with done
// high, in the following cycle.
// Throughput: one request per cycle; busy stays low, since every cell shifts in one step.
// Reset: rst clears the item count and the result strobe; stored items need no reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module positional_list_store #(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      action,
  input  logic [pls_pkg::POS_W-1:0]       position,
  input  logic [pls_pkg::ITEM_IN_W-1:0]   item_in,
  output logic                            done,
  output logic                            success,
  output logic [pls_pkg::ITEM_OUT_W-1:0]  item_out,
  output logic [pls_pkg::CNT_OUT_W-1:0]   item_count,
  output logic                            empty_res
);
  import pls_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic                  accept;
  pls_cmd_t              cmd;
  logic                  ok;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [ITEM_WIDTH-1:0] item;
  logic [ITEM_WIDTH-1:0] data [DEPTH];
  logic [ITEM_WIDTH-1:0] rd_data [DEPTH];
  logic [ITEM_WIDTH-1:0] rd_all;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign item   = ITEM_WIDTH'(item_in);

  pls_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .accept     (accept),
    .action     (action),
    .position   (position),
    .count      (count),
    .cmd        (cmd),
    .ok         (ok),
    .count_next (count_next)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ITEM_WIDTH-1:0] left;
    logic [ITEM_WIDTH-1:0] right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = data[i+1];
    end

    pls_cell #(
      .INDEX      (i),
      .ITEM_WIDTH (ITEM_WIDTH)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .item    (item),
      .left    (left),
      .right   (right),
      .data    (data[i]),
      .rd_data (rd_data[i])
    );
  end

  always_comb begin
    rd_all = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_all = rd_all | rd_data[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      success    <= ok;
      item_out   <= ITEM_OUT_W'(rd_all);
      item_count <= CNT_OUT_W'(count_next);
      empty_res  <= (count_next == '0);
    end
  end

endmodule

// File: rtl/core/pls_checker.sv
module pls_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  action,
  input logic [4:0]  position,
  input logic [31:0] item_in,
  input logic        done,
  input logic        success,
  input logic [31:0] item_out,
  input logic [4:0]  item_count,
  input logic        empty_res
);

  // No result may appear in the cycle after reset.
  a_no_done_after_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  // Every accepted request gets its result in the next cycle.
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("accepted request without a result");

  // No result is invented without a request.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without a request");

  // The empty flag agrees with the reported count.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (empty_res == (item_count == 5'd0)))
    else $error("empty flag disagrees with count");

  // A failed request reads back zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !success) |-> (item_out == 32'd0))
    else $error("failed request returned data");

endmodule

bind positional_list_store pls_checker u_pls_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .action     (action),
  .position   (position),
  .item_in    (item_in),
  .done       (done),
  .success    (success),
  .item_out   (item_out),
  .item_count (item_count),
  .empty_res  (empty_res)
);

// File: tb/tb_positional_list_store.sv
module tb_positional_list_store;
  timeunit 1ns;
  timeprecision 1ps;

  import pls_pkg::*;

  localparam int DEPTH       = 16;
  localparam int ITEM_WIDTH  = 32;
  localparam int RANDOM_REQS = 1750;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_t;

  typedef struct packed {
    logic                  success;
    logic [ITEM_OUT_W-1:0] item;
    logic [CNT_OUT_W-1:0]  count;
    logic                  empty;
  } list_result_t;

  // Mirrors the list contents and queues the response each accepted request must produce.
  class list_scoreboard;
    logic [ITEM_OUT_W-1:0] slots[DEPTH];
    int                    held;
    list_result_t          awaited[$];
    int                    faults;

    function new();
      held = 0;
      faults = 0;
    endfunction

    function void note_request(logic [1:0] act, logic [POS_W-1:0] pos,
                               logic [ITEM_IN_W-1:0] item);
      list_result_t r;
      int p;
      int i;
      p = int'(pos);
      r.success = 1'b0;
      r.item = '0;
      case (act)
        ACT_INSERT: begin
          if (p >= 1 && p <= held + 1 && held < DEPTH) begin
            for (i = held; i >= p; i--) slots[i] = slots[i-1];
            slots[p-1] = item[ITEM_WIDTH-1:0];
            held++;
            r.success = 1'b1;
          end
        end
        ACT_REMOVE: begin
          if (p >= 1 && p <= held) begin
            for (i = p - 1; i + 1 < held; i++) slots[i] = slots[i+1];
            held--;
            r.success = 1'b1;
          end
        end
        ACT_RETRIEVE: begin
          if (p >= 1 && p <= held) begin
            r.item = slots[p-1];
            r.success = 1'b1;
          end
        end
        default: ;
      endcase
      r.count = CNT_OUT_W'(held);
      r.empty = (held == 0);
      awaited.push_back(r);
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (awaited.size() == 0) begin
        $error("response with no request outstanding");
        faults++;
        return;
      end
      want = awaited.pop_front();
      if (got.success !== want.success) begin
        $error("success: expected %0h, actual %0h", want.success, got.success);
        faults++;
      end
      if (got.item !== want.item) begin
        $error("item_out: expected %0h, actual %0h", want.item, got.item);
        faults++;
      end
      if (got.count !== want.count) begin
        $error("item_count: expected %0d, actual %0d", want.count, got.count);
        faults++;
      end
      if (got.empty !== want.empty) begin
        $error("empty_res: expected %0h, actual %0h", want.empty, got.empty);
        faults++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [1:0]            action;
  logic [POS_W-1:0]      position;
  logic [ITEM_IN_W-1:0]  item_in;
  logic                  done;
  logic                  success;
  logic [ITEM_OUT_W-1:0] item_out;
  logic [CNT_OUT_W-1:0]  item_count;
  logic                  empty_res;

  list_scoreboard board = new();
  bit             gaps_on = 1'b1;

  positional_list_store #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .position   (position),
    .item_in    (item_in),
    .done       (done),
    .success    (success),
    .item_out   (item_out),
    .item_count (item_count),
    .empty_res  (empty_res)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The response of the previous request is checked before the new request is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) board.check_result('{success, item_out, item_count, empty_res});
      if (start && !busy) board.note_request(action, position, item_in);
    end
  end

  task automatic send_request(input logic [1:0] act, input int pos,
                              input logic [ITEM_IN_W-1:0] item);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 33) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start    <= 1'b1;
    action   <= act;
    position <= POS_W'(pos);
    item_in  <= item;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    phase_t phase;
    int     phase_left;
    int     roll;
    int     hi;
    int     pos;
    logic [1:0]           act;
    logic [ITEM_IN_W-1:0] item;

    rst      = 1'b1;
    start    = 1'b0;
    action   = ACT_INSERT;
    position = '0;
    item_in  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Failures on an empty list, bad positions, then a short list built and torn down.
    send_request(ACT_RETRIEVE, 1, 32'h1111_1111);
    send_request(ACT_REMOVE, 1, 32'h0);
    send_request(ACT_UNUSED, 1, 32'hDEAD_BEEF);
    send_request(ACT_INSERT, 0, 32'hAAAA_AAAA);
    send_request(ACT_INSERT, 2, 32'h5555_5555);
    send_request(ACT_INSERT, 1, 32'hFFFF_FFFF);
    send_request(ACT_INSERT, 2, 32'h0);
    send_request(ACT_INSERT, 1, 32'h1234_5678);
    send_request(ACT_RETRIEVE, 1, 32'h0);
    send_request(ACT_RETRIEVE, 2, 32'hFFFF_FFFF);
    send_request(ACT_RETRIEVE, 3, 32'h0);
    send_request(ACT_RETRIEVE, 4, 32'h0);
    send_request(ACT_RETRIEVE, 0, 32'h0);
    send_request(ACT_REMOVE, 0, 32'h0);
    send_request(ACT_REMOVE, 4, 32'h0);
    send_request(ACT_INSERT, 17, 32'h8000_0001);
    send_request(ACT_INSERT, 16, 32'h7FFF_FFFE);
    send_request(ACT_UNUSED, 2, 32'h0);
    send_request(ACT_REMOVE, 2, 32'h0);
    send_request(ACT_REMOVE, 1, 32'h0);
    send_request(ACT_REMOVE, 1, 32'h0);
    send_request(ACT_RETRIEVE, 1, 32'h0);

    // Phases lean toward filling or draining so the full and empty limits are hit often.
    phase = PHASE_FILL;
    phase_left = 0;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      gaps_on = !(n >= 700 && n < 1100);
      if (phase_left == 0) begin
        phase = phase_t'($urandom_range(2));
        phase_left = $urandom_range(20, 80);
      end
      phase_left--;
      roll = $urandom_range(99);
      case (phase)
        PHASE_FILL:  act = (roll < 70) ? ACT_INSERT : (roll < 90) ? ACT_RETRIEVE : ACT_REMOVE;
        PHASE_DRAIN: act = (roll < 70) ? ACT_REMOVE : (roll < 90) ? ACT_RETRIEVE : ACT_INSERT;
        default:     act = (roll < 33) ? ACT_INSERT : (roll < 66) ? ACT_REMOVE : ACT_RETRIEVE;
      endcase
      hi = (act == ACT_INSERT) ? board.held + 1 : board.held;
      if (hi < 1) hi = 1;
      roll = $urandom_range(99);
      if (roll < 10) begin
        pos = $urandom_range(17);
        if ($urandom_range(3) == 0) act = 2'($urandom_range(3));
      end else if (roll < 25) begin
        pos = 1;
      end else if (roll < 40) begin
        pos = hi;
      end else begin
        pos = $urandom_range(hi, 1);
      end
      roll = $urandom_range(99);
      item = (roll < 8) ? '0 : (roll < 16) ? '1 : $urandom;
      send_request(act, pos, item);
    end

    @(negedge clk);
    start <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (board.faults == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
